// ===== hw/rtl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg: shared types and codes of the sortable deque store.
// Command codes, status codes and the word types of both channels.
// ----------------------------------------------------------------------------
package sds_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SORT       = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_e;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [1:0]         status;
    logic [6:0]         count;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_POP,
    ST_QUERY,
    ST_ROT_RD,
    ST_ROT_WR,
    ST_MRG_SETUP,
    ST_MRG_RDA,
    ST_MRG_RDB,
    ST_MRG_CMP,
    ST_MRG_NEXT,
    ST_CPY,
    ST_RESULT
  } state_e;

endpackage

// ===== hw/rtl/sortable_deque_store_core.sv =====
// ----------------------------------------------------------------------------
// sortable_deque_store_core: bounded deque of signed values with merge sort.
// Push, pop, stable sort and membership query under one sequencer.
// ----------------------------------------------------------------------------
// Each command word produces one result word; the block accepts no new word
// until that result has been taken. A membership query scans the held values
// in order. A sort first rotates the held values to start at slot zero and
// then runs ceil(log2(n)) bottom-up merge passes; each merged value goes
// through the single port of the value or scratch RAM, and a final copy back
// follows when the pass count is even, zero included. One comparator and these
// two single-port RAMs do all the work.
module sortable_deque_store_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sds_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sds_pkg::out_word_t out_word_o
);
  import sds_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = AW + 2;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [DATA_WIDTH-1:0] SignC = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  out_word_t res_q, res_d;
  logic [CW:0] i_q, i_d;
  logic [CW:0] a_q, a_d, b_q, b_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d, lo_q, lo_d;
  logic [WW-1:0] width_q, width_d;
  logic src_q, src_d;
  logic [DATA_WIDTH-1:0] ra_q, ra_d;

  logic e_we, s_we;
  logic [AW-1:0] e_addr, s_addr;
  logic [DATA_WIDTH-1:0] e_wdata, s_wdata, e_rdata, s_rdata;

  sds_ram #(.Width(DATA_WIDTH), .Depth(CAPACITY)) u_entries (
    .clk_i, .we_i(e_we), .addr_i(e_addr), .wdata_i(e_wdata), .rdata_o(e_rdata)
  );
  sds_ram #(.Width(DATA_WIDTH), .Depth(CAPACITY)) u_scratch (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata)
  );

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = s - (AW+1)'(CAPACITY);
    return (s >= (AW+1)'(CAPACITY)) ? t[AW-1:0] : s[AW-1:0];
  endfunction

  function automatic logic signed [31:0] sext(input logic [DATA_WIDTH-1:0] d);
    logic signed [63:0] w;
    w = 64'($signed(d));
    return w[31:0];
  endfunction

  logic [AW-1:0] slot_i;
  logic [DATA_WIDTH-1:0] src_rd;
  logic [CW:0] cnt_x;
  assign slot_i = wrap({1'b0, head_q} + (AW+1)'(i_q[AW:0]));
  assign src_rd = src_q ? s_rdata : e_rdata;
  assign cnt_x = {1'b0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; val_q <= val_d; res_q <= res_d; i_q <= i_d;
    a_q <= a_d; b_q <= b_d; k_q <= k_d; mid_q <= mid_d; hi_q <= hi_d;
    lo_q <= lo_d; width_q <= width_d; src_q <= src_d; ra_q <= ra_d;
  end

  always_comb begin
    logic [CW:0] m, h;
    logic [WW-1:0] w2;
    state_d = state_q; head_d = head_q; cnt_d = cnt_q; cmd_d = cmd_q;
    val_d = val_q; res_d = res_q; i_d = i_q; a_d = a_q; b_d = b_q; k_d = k_q;
    mid_d = mid_q; hi_d = hi_q; lo_d = lo_q; width_d = width_q; src_d = src_q;
    ra_d = ra_q;
    e_we = 1'b0; s_we = 1'b0; e_addr = '0; s_addr = '0;
    e_wdata = src_rd; s_wdata = src_rd;
    m = '0; h = '0; w2 = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d = in_word_i.command;
          val_d = DATA_WIDTH'(64'($signed(in_word_i.value)));
          res_d = '0;
          i_d = '0;
          state_d = ST_RESULT;
          case (in_word_i.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (cnt_q >= CapC) begin
                res_d.status = STATUS_FULL;
              end else begin
                e_we = 1'b1;
                e_wdata = DATA_WIDTH'(64'($signed(in_word_i.value)));
                if (in_word_i.command == CMD_PUSH_FRONT) begin
                  head_d = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
                  e_addr = head_d;
                end else begin
                  e_addr = wrap({1'b0, head_q} + (AW+1)'(cnt_q));
                end
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (cnt_q == '0) begin
                res_d.status = STATUS_EMPTY;
              end else begin
                e_addr = (in_word_i.command == CMD_POP_FRONT) ? head_q :
                         wrap({1'b0, head_q} + (AW+1)'(cnt_q - 1'b1));
                state_d = ST_RD_WAIT;
              end
            end
            CMD_QUERY: begin
              if (cnt_q != '0) begin
                e_addr = head_q;
                state_d = ST_QUERY;
              end
            end
            CMD_SORT: state_d = ST_ROT_RD;
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        // Keep the popped slot addressed so the registered read still holds it.
        e_addr = (cmd_q == CMD_POP_FRONT) ? head_q :
                 wrap({1'b0, head_q} + (AW+1)'(cnt_q - 1'b1));
        state_d = ST_POP;
      end
      ST_POP: begin
        res_d.read_value = sext(e_rdata);
        if (cmd_q == CMD_POP_FRONT) head_d = wrap({1'b0, head_q} + 1'b1);
        cnt_d = cnt_q - 1'b1;
        state_d = ST_RESULT;
      end
      ST_QUERY: begin
        // Read of slot i was issued last cycle; compare it now.
        e_addr = wrap({1'b0, head_q} + (AW+1)'(i_q[AW:0] + 1'b1));
        if (e_rdata == val_q) begin
          res_d.found = 1'b1;
          state_d = ST_RESULT;
        end else if (i_q + 1'b1 >= cnt_x) begin
          state_d = ST_RESULT;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_ROT_RD: begin
        if (i_q >= cnt_x) begin
          head_d = '0;
          i_d = '0;
          width_d = WW'(1);
          src_d = 1'b1;
          state_d = ST_MRG_SETUP;
        end else begin
          e_addr = slot_i;
          state_d = ST_ROT_WR;
        end
      end
      ST_ROT_WR: begin
        // Rotated copy lands in scratch, which then acts as the first source.
        s_we = 1'b1;
        s_addr = i_q[AW-1:0];
        s_wdata = e_rdata;
        i_d = i_q + 1'b1;
        state_d = ST_ROT_RD;
      end
      ST_MRG_SETUP: begin
        if ((CW+1)'(width_q) >= cnt_x || {1'b0, width_q} >= WW'(1) + (WW+1)'(cnt_q)) begin
          i_d = '0;
          k_d = '0;
          state_d = src_q ? ST_CPY : ST_RESULT;
        end else if (lo_q >= cnt_x) begin
          lo_d = '0;
          width_d = width_q << 1;
          src_d = ~src_q;
        end else begin
          m = lo_q + (CW+1)'(width_q);
          w2 = width_q << 1;
          h = lo_q + (CW+1)'(w2);
          if (m > cnt_x) m = cnt_x;
          if (h > cnt_x) h = cnt_x;
          a_d = lo_q; b_d = m; k_d = lo_q; mid_d = m; hi_d = h;
          state_d = ST_MRG_NEXT;
        end
      end
      ST_MRG_NEXT: begin
        if (a_q >= mid_q && b_q >= hi_q) begin
          lo_d = hi_q;
          state_d = ST_MRG_SETUP;
        end else begin
          e_addr = (a_q < mid_q) ? a_q[AW-1:0] : b_q[AW-1:0];
          s_addr = e_addr;
          state_d = ST_MRG_RDA;
        end
      end
      ST_MRG_RDA: begin
        ra_d = src_rd;
        if (a_q < mid_q && b_q < hi_q) begin
          e_addr = b_q[AW-1:0];
          s_addr = b_q[AW-1:0];
          state_d = ST_MRG_RDB;
        end else begin
          state_d = ST_MRG_CMP;
          b_d = (a_q < mid_q) ? b_q : b_q + 1'b1;
          a_d = (a_q < mid_q) ? a_q + 1'b1 : a_q;
        end
      end
      ST_MRG_RDB: begin
        // Take the left value unless the right one orders strictly below it.
        if ((ra_q ^ SignC) <= (src_rd ^ SignC)) begin
          a_d = a_q + 1'b1;
        end else begin
          ra_d = src_rd;
          b_d = b_q + 1'b1;
        end
        state_d = ST_MRG_CMP;
      end
      ST_MRG_CMP: begin
        e_wdata = ra_q; s_wdata = ra_q;
        e_addr = k_q[AW-1:0]; s_addr = k_q[AW-1:0];
        if (src_q) e_we = 1'b1; else s_we = 1'b1;
        k_d = k_q + 1'b1;
        state_d = ST_MRG_NEXT;
      end
      ST_CPY: begin
        if (i_q >= cnt_x) begin
          state_d = ST_RESULT;
        end else begin
          s_addr = i_q[AW-1:0];
          state_d = ST_CPY;
          if (k_q == '1) begin
            e_we = 1'b1;
            e_addr = a_q[AW-1:0];
            e_wdata = s_rdata;
            i_d = i_q + 1'b1;
            k_d = '0;
          end else begin
            a_d = i_q;
            k_d = '1;
          end
        end
      end
      ST_RESULT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
          lo_d = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && in_valid_i && in_word_i.command == CMD_SORT) begin
      lo_d = '0;
    end
  end

  always_comb begin
    out_word_o = res_q;
    out_word_o.count = 7'(cnt_q);
  end

endmodule

// ===== hw/rtl/sds_ram.sv =====
// ----------------------------------------------------------------------------
// sds_ram: generic single-port RAM.
// One address per cycle, read every cycle and written when enabled; the read data is registered (old value on a write).
// ----------------------------------------------------------------------------
module sds_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
